/* sv/sha256_pkg.sv */
// ============================================================================
// SHA-256 package
// Shared types, constants and round functions for the byte stream hasher.
// ============================================================================
package sha256_pkg;

    localparam int unsigned WORD_W = 32;

    // Bytes in one message block and the fill position of its last byte.
    localparam int unsigned BLOCK_BYTES = 64;
    localparam logic [5:0]  LAST_FILL   = 6'(BLOCK_BYTES - 1);

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_byte;   // write the request byte at the fill position
        logic store_pad;    // write the 0x80 marker at the fill position
        logic store_zero;   // write zero at the fill position
        logic store_len;    // write one length byte at the fill position
        logic bump_total;   // count one message byte
        logic load_work;    // copy the chaining words into the round registers
        logic round_step;   // run one compression round
        logic fold;         // add the working words into the chaining words
        logic reinit;       // return to the initial hash values
        logic clear_fill;   // fill position back to zero
    } sha256_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } sha256_stat_t;

    localparam word_t H_INIT [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B,
        32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01,
        32'h243185BE, 32'h550C7DC3, 32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7,
        32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA, 32'h983E5152,
        32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
        32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC,
        32'h53380D13, 32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3, 32'hD192E819,
        32'hD6990624, 32'hF40E3585, 32'h106AA070, 32'h19A4C116, 32'h1E376C08,
        32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F,
        32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    function automatic word_t ror(input word_t v, input int unsigned n);
        ror = (v >> n) | (v << (WORD_W - n));
    endfunction

endpackage

/* sv/sha256_if.sv */
// ============================================================================
// Stream channel
// Valid/ready channel carrying one payload of a given type.
// ============================================================================
interface sha256_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* sv/sha256_datapath.sv */
// ============================================================================
// SHA-256 datapath
// Block buffer, message schedule window, round registers and chaining words.
// ============================================================================
module sha256_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sha256_pkg::sha256_cmd_t   cmd,
    input  logic [7:0]                in_byte,
    input  logic [2:0]                out_sel,
    output sha256_pkg::sha256_stat_t  stat,
    output sha256_pkg::word_t         digest
);
    // Bytes are written straight into the sixteen-word schedule window, which
    // then shifts in place during the rounds. Every block writes all 64 byte
    // positions before its compression starts, so nothing stale is hashed.
    sha256_pkg::word_t w_reg [16];
    sha256_pkg::word_t s_reg [8];
    sha256_pkg::word_t h_reg [8];
    logic [5:0]        fill_reg;
    logic [5:0]        round_reg;
    logic [60:0]       total_reg;
    logic [63:0]       bits;
    logic [7:0]        wr_byte;
    logic              wr_en;

    sha256_pkg::word_t w_new, t1, t2, x, y, e, a;

    assign bits = {total_reg, 3'b000};

    always_comb
    begin
        wr_en   = cmd.store_byte | cmd.store_pad | cmd.store_zero | cmd.store_len;
        wr_byte = 8'h00;
        if (cmd.store_byte)
        begin
            wr_byte = in_byte;
        end
        else if (cmd.store_pad)
        begin
            wr_byte = sha256_pkg::PAD_MARK;
        end
        else if (cmd.store_len)
        begin
            wr_byte = bits[8*(7 - fill_reg[2:0]) +: 8];
        end
    end

    always_comb
    begin
        x     = w_reg[1];
        y     = w_reg[14];
        w_new = (sha256_pkg::ror(y, 17) ^ sha256_pkg::ror(y, 19) ^ (y >> 10))
              + w_reg[9]
              + (sha256_pkg::ror(x, 7) ^ sha256_pkg::ror(x, 18) ^ (x >> 3))
              + w_reg[0];
        e  = s_reg[4];
        a  = s_reg[0];
        t1 = s_reg[7] + (sha256_pkg::ror(e, 6) ^ sha256_pkg::ror(e, 11)
                         ^ sha256_pkg::ror(e, 25))
           + ((e & s_reg[5]) ^ (~e & s_reg[6]))
           + sha256_pkg::ROUND_K[round_reg] + w_reg[0];
        t2 = (sha256_pkg::ror(a, 2) ^ sha256_pkg::ror(a, 13) ^ sha256_pkg::ror(a, 22))
           + ((a & s_reg[1]) ^ (a & s_reg[2]) ^ (s_reg[1] & s_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
            begin
                s_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            s_reg[7] <= s_reg[6];
            s_reg[6] <= s_reg[5];
            s_reg[5] <= s_reg[4];
            s_reg[4] <= s_reg[3] + t1;
            s_reg[3] <= s_reg[2];
            s_reg[2] <= s_reg[1];
            s_reg[1] <= s_reg[0];
            s_reg[0] <= t1 + t2;
        end
        else if (wr_en)
        begin
            // Big-endian: the first byte of a word lands in its top lane.
            w_reg[fill_reg[5:2]][8*(3 - fill_reg[1:0]) +: 8] <= wr_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            round_reg <= '0;
            total_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::H_INIT[i];
            end
        end
        else
        begin
            if (cmd.clear_fill)
            begin
                fill_reg <= '0;
            end
            else if (wr_en)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.reinit)
            begin
                total_reg <= '0;
            end
            else if (cmd.bump_total)
            begin
                total_reg <= total_reg + 61'd1;
            end
            if (cmd.load_work)
            begin
                round_reg <= '0;
            end
            else if (cmd.round_step)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.reinit)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= sha256_pkg::H_INIT[i];
                end
            end
            else if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + s_reg[i];
                end
            end
        end
    end

    assign stat.fill       = fill_reg;
    assign stat.round_last = (round_reg == 6'd63);
    assign digest          = h_reg[out_sel];

endmodule

/* sv/sha256_ctrl.sv */
// ============================================================================
// SHA-256 controller
// Sequences buffering, padding, compression and digest output.
// ============================================================================
module sha256_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_mode,
    output logic                     in_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               out_sel,
    input  sha256_pkg::sha256_stat_t stat,
    output sha256_pkg::sha256_cmd_t  cmd
);
    sha256_pkg::state_t state_reg, state_next;
    logic               finish_reg, finish_next;   // block being hashed holds padding
    logic [2:0]         sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha256_pkg::ST_IDLE;
            finish_reg <= 1'b0;
            sel_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            finish_reg <= finish_next;
            sel_reg    <= sel_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        finish_next = finish_reg;
        sel_next    = sel_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!in_mode)
                    begin
                        cmd.store_byte = 1'b1;
                        cmd.bump_total = 1'b1;
                        finish_next    = 1'b0;
                        if (stat.fill == sha256_pkg::LAST_FILL)
                        begin
                            state_next = sha256_pkg::ST_LOAD;
                        end
                    end
                    else
                    begin
                        cmd.store_pad = 1'b1;
                        state_next    = sha256_pkg::ST_PAD_ZERO;
                    end
                end
            end
            sha256_pkg::ST_PAD_ZERO:
            begin
                if (stat.fill == sha256_pkg::LEN_START && !finish_reg)
                begin
                    state_next = sha256_pkg::ST_PAD_LEN;
                end
                else if (stat.fill == 6'd0 && !finish_reg)
                begin
                    // Marker did not leave room for the length: hash this block first.
                    finish_next = 1'b1;
                    state_next  = sha256_pkg::ST_LOAD;
                end
                else
                begin
                    cmd.store_zero = 1'b1;
                    if (finish_reg && stat.fill == 6'd55)
                    begin
                        finish_next = 1'b0;
                        state_next  = sha256_pkg::ST_PAD_LEN;
                    end
                end
            end
            sha256_pkg::ST_PAD_LEN:
            begin
                cmd.store_len = 1'b1;
                if (stat.fill == sha256_pkg::LAST_FILL)
                begin
                    finish_next = 1'b1;
                    state_next  = sha256_pkg::ST_LOAD;
                end
            end
            sha256_pkg::ST_LOAD:
            begin
                cmd.load_work = 1'b1;
                state_next    = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (stat.round_last)
                begin
                    state_next = sha256_pkg::ST_FOLD;
                end
            end
            sha256_pkg::ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (finish_reg && stat.fill == 6'd0 && sel_reg == 3'd1)
                begin
                    // Length block done.
                    sel_next   = '0;
                    state_next = sha256_pkg::ST_EMIT;
                end
                else if (finish_reg)
                begin
                    // Overflow block done; the next block is all padding and length.
                    state_next = sha256_pkg::ST_PAD_ZERO;
                end
                else
                begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end
            sha256_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    sel_next = sel_reg + 3'd1;
                    if (sel_reg == 3'd7)
                    begin
                        cmd.reinit     = 1'b1;
                        cmd.clear_fill = 1'b1;
                        finish_next    = 1'b0;
                        state_next     = sha256_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
        // Length block marks itself by loading sel 1 before its compression.
        if (state_reg == sha256_pkg::ST_PAD_LEN && stat.fill == sha256_pkg::LAST_FILL)
        begin
            sel_next = 3'd1;
        end
        else if (state_reg == sha256_pkg::ST_PAD_ZERO && stat.fill == 6'd0 && !finish_reg)
        begin
            sel_next = 3'd0;
        end
    end

    assign out_sel = sel_reg;

endmodule

/* sv/sha256_byte_stream_hasher.sv */
// ============================================================================
// SHA-256 byte stream hasher
// Absorbs message bytes, pads on finish and returns the 256-bit digest.
// ============================================================================
//
//  channel    direction  payload                               per request
//  ---------  ---------  ------------------------------------  -----------------
//  in_ch      sink       mode, message_byte                    one byte / finish
//  out_ch     source     digest_word, word_index, last_word    one digest word
//
// An absorbed byte is written straight into the block buffer; the 64th byte
// of a block adds a load step, 64 rounds of the single shared round unit and
// a fold step. A finish writes the padding one byte a cycle up to the end of
// the block, runs one or two compressions and then offers the eight digest
// words, one per accepted output request. Reset restores the initial hash
// values and empties the buffer. While the digest waits on out_ch, no input
// request is taken.

module sha256_byte_stream_hasher (
    input logic clk,
    input logic rst_n,
    sha256_if.sink   in_ch,
    sha256_if.source out_ch
);
    sha256_pkg::sha256_cmd_t  cmd;
    sha256_pkg::sha256_stat_t stat;
    sha256_pkg::word_t        digest;
    logic [2:0]               sel;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_mode   (in_ch.payload.mode),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_sel   (sel),
        .stat      (stat),
        .cmd       (cmd)
    );

    sha256_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_byte (in_ch.payload.message_byte),
        .out_sel (sel),
        .stat    (stat),
        .digest  (digest)
    );

    assign out_ch.payload.digest_word = digest;
    assign out_ch.payload.word_index  = sel;
    assign out_ch.payload.last_word   = (sel == 3'd7);

endmodule

/* sv/sha256_checker.sv */
// ============================================================================
// SHA-256 port checker
// Watches the top level's channels for ordering and holding of the digest words and for input taken during output.
// ============================================================================
module sha256_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] word_index,
    input logic       last_word
);
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match word 7");

    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_word) |=>
            (out_valid && word_index == $past(word_index) + 3'd1))
        else $error("digest words out of order");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("input taken during digest output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(word_index)))
        else $error("stalled digest word changed");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .word_index (out_ch.payload.word_index),
    .last_word  (out_ch.payload.last_word)
);
